// File: hw/rtl/bibm_pkg.sv
// Types and constants for the best-IoU box matcher.
`default_nettype none

package bibm_pkg;

  localparam int unsigned CoordW = 13;
  localparam int unsigned SizeW  = 12;
  localparam int unsigned BoxW   = 2 * CoordW + 2 * SizeW;
  localparam int unsigned AreaW  = 2 * SizeW;
  localparam int unsigned UnionW = AreaW + 1;
  localparam int unsigned RemW   = UnionW + 1;
  localparam int unsigned IouW   = 17;
  localparam int unsigned OutIdxW = 6;
  localparam int unsigned DivSteps = IouW;
  localparam int unsigned MulSteps = 3;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_READ = 8'b0000_0010,
    ST_GEOM = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_UNI  = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_CMP  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic        [SizeW-1:0]  w;
    logic        [SizeW-1:0]  h;
  } box_t;

endpackage

`default_nettype wire

// File: hw/rtl/best_iou_box_matcher.sv
// Top level of the best-IoU box matcher: box table, sequencer and shared arithmetic.
//
// Input stream (s_axis): tuser carries the kind (load, query, clear), tdata the box.
// A load stores the box at the next free table slot, or is dropped when the table
// is full. A clear empties the table. Load and clear give no output. A query
// compares the box against every stored entry and returns one output
// transaction (m_axis) with the best IoU in Q1.16, the index of the first
// entry reaching it and a matched flag in tuser.
// A query walks the table one entry at a time through one 12x12 multiplier and
// one restoring divider: an entry that does not overlap passes read, geometry
// and the overlap test; one that does passes read, geometry, 3 products, union,
// 17 quotient bits and compare. A final state posts the result.
// s_axis_tready is low for the whole query. The result sits in an output
// register; if the receiver stalls, loads and clears still proceed while the
// matcher is idle, and the next query finishes its walk and then waits until
// that register is free. Reset empties the table and drops any pending output;
// table contents are not cleared, only the count.
`default_nettype none

module best_iou_box_matcher #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // box_x[12:0], box_y[25:13], box_w[37:26], box_h[49:38], zero pad [55:50]
  input  wire logic [55:0] s_axis_tdata,
  // kind[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // best_iou[16:0], best_index[22:17], zero pad [23]
  output logic [23:0]      m_axis_tdata,
  // matched[0]
  output logic             m_axis_tuser
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned SW   = bibm_pkg::SizeW;
  localparam int unsigned CW   = bibm_pkg::CoordW;
  localparam int unsigned AW   = bibm_pkg::AreaW;
  localparam int unsigned UW   = bibm_pkg::UnionW;
  localparam int unsigned RW   = bibm_pkg::RemW;
  localparam int unsigned QW   = bibm_pkg::IouW;
  localparam int unsigned OW   = bibm_pkg::OutIdxW;

  bibm_pkg::state_e state_q, state_d;

  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;
  logic [4:0]      step_q;
  logic            m_valid_q;
  logic            any_q;

  bibm_pkg::box_t  mem_q [TABLE_DEPTH];
  bibm_pkg::box_t  ent_q;
  bibm_pkg::box_t  gt_q;
  bibm_pkg::box_t  in_box;

  logic [SW-1:0]   iw_q, ih_q;
  logic            ov_q;
  logic [AW-1:0]   inter_q, a1_q, a2_q;
  logic [UW-1:0]   uni_q;
  logic [RW-1:0]   rem_q;
  logic [QW-1:0]   quo_q;
  logic [QW-1:0]   best_q;
  logic [IdxW-1:0] best_idx_q;

  logic [QW-1:0]   out_iou_q;
  logic [OW-1:0]   out_idx_q;
  logic            out_match_q;

  logic            s_fire, m_fire, out_free, last_entry;
  logic            is_load, is_query, is_clear, table_full;

  logic signed [CW:0]   ga_r, ea_r, ga_b, ea_b, lx, ty, rx, by;
  logic signed [CW+1:0] iw_s, ih_s;
  logic [SW-1:0]   mul_a, mul_b;
  logic [AW-1:0]   mul_p;
  logic            div_ge;
  logic [RW-1:0]   div_rem;
  logic [IdxW+OW-1:0] best_idx_ext;

  assign in_box = bibm_pkg::box_t'({s_axis_tdata[12:0], s_axis_tdata[25:13],
                                    s_axis_tdata[37:26], s_axis_tdata[49:38]});

  assign s_axis_tready = (state_q == bibm_pkg::ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_valid_q && m_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign is_load       = (s_axis_tuser == bibm_pkg::KIND_LOAD);
  assign is_query      = (s_axis_tuser == bibm_pkg::KIND_QUERY);
  assign is_clear      = (s_axis_tuser == bibm_pkg::KIND_CLEAR);
  assign table_full    = (count_q == CntW'(TABLE_DEPTH));
  assign last_entry    = ((CntW'(idx_q) + CntW'(1)) == count_q);

  // Overlap geometry between the query box and the current entry.
  assign ga_r = $signed({gt_q.x[CW-1], gt_q.x}) + $signed({2'b00, gt_q.w[SW-1:0]});
  assign ea_r = $signed({ent_q.x[CW-1], ent_q.x}) + $signed({2'b00, ent_q.w[SW-1:0]});
  assign ga_b = $signed({gt_q.y[CW-1], gt_q.y}) + $signed({2'b00, gt_q.h[SW-1:0]});
  assign ea_b = $signed({ent_q.y[CW-1], ent_q.y}) + $signed({2'b00, ent_q.h[SW-1:0]});
  assign lx   = (gt_q.x > ent_q.x) ? {gt_q.x[CW-1], gt_q.x} : {ent_q.x[CW-1], ent_q.x};
  assign ty   = (gt_q.y > ent_q.y) ? {gt_q.y[CW-1], gt_q.y} : {ent_q.y[CW-1], ent_q.y};
  assign rx   = (ga_r < ea_r) ? ga_r : ea_r;
  assign by   = (ga_b < ea_b) ? ga_b : ea_b;
  assign iw_s = {rx[CW], rx} - {lx[CW], lx};
  assign ih_s = {by[CW], by} - {ty[CW], ty};

  // Shared multiplier: intersection, query area, entry area.
  always_comb begin
    case (step_q)
      5'd0: begin
        mul_a = iw_q;
        mul_b = ih_q;
      end
      5'd1: begin
        mul_a = gt_q.w;
        mul_b = gt_q.h;
      end
      default: begin
        mul_a = ent_q.w;
        mul_b = ent_q.h;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // One restoring-division step.
  assign div_ge  = (rem_q >= {1'b0, uni_q});
  assign div_rem = div_ge ? (rem_q - {1'b0, uni_q}) : rem_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bibm_pkg::ST_IDLE: begin
        if (s_fire && is_query) begin
          state_d = (count_q == '0) ? bibm_pkg::ST_DONE : bibm_pkg::ST_READ;
        end
      end
      bibm_pkg::ST_READ: state_d = bibm_pkg::ST_GEOM;
      bibm_pkg::ST_GEOM: state_d = bibm_pkg::ST_MUL;
      bibm_pkg::ST_MUL: begin
        if (!ov_q) begin
          state_d = last_entry ? bibm_pkg::ST_DONE : bibm_pkg::ST_READ;
        end else if (step_q == 5'(bibm_pkg::MulSteps - 1)) begin
          state_d = bibm_pkg::ST_UNI;
        end
      end
      bibm_pkg::ST_UNI: state_d = bibm_pkg::ST_DIV;
      bibm_pkg::ST_DIV: begin
        if (step_q == 5'(bibm_pkg::DivSteps - 1)) begin
          state_d = bibm_pkg::ST_CMP;
        end
      end
      bibm_pkg::ST_CMP: state_d = last_entry ? bibm_pkg::ST_DONE : bibm_pkg::ST_READ;
      bibm_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = bibm_pkg::ST_IDLE;
        end
      end
      default: state_d = bibm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bibm_pkg::ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      step_q    <= '0;
      m_valid_q <= 1'b0;
      any_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_fire && is_load && !table_full) begin
        count_q <= count_q + CntW'(1);
      end
      if (s_fire && is_clear) begin
        count_q <= '0;
      end
      if (s_fire && is_query) begin
        idx_q <= '0;
        any_q <= 1'b0;
      end
      if (state_q == bibm_pkg::ST_GEOM || state_q == bibm_pkg::ST_UNI) begin
        step_q <= '0;
      end
      if (state_q == bibm_pkg::ST_MUL || state_q == bibm_pkg::ST_DIV) begin
        step_q <= step_q + 5'd1;
      end
      if ((state_q == bibm_pkg::ST_MUL && !ov_q) || state_q == bibm_pkg::ST_CMP) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (state_q == bibm_pkg::ST_CMP) begin
        any_q <= 1'b1;
      end
      if (state_q == bibm_pkg::ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_fire) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && is_load && !table_full) begin
      mem_q[count_q[IdxW-1:0]] <= in_box;
    end
    if (state_q == bibm_pkg::ST_READ) begin
      ent_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && is_query) begin
      gt_q       <= in_box;
      best_q     <= '0;
      best_idx_q <= '0;
    end
    if (state_q == bibm_pkg::ST_GEOM) begin
      iw_q <= iw_s[SW-1:0];
      ih_q <= ih_s[SW-1:0];
      ov_q <= (iw_s > 0) && (ih_s > 0);
    end
    if (state_q == bibm_pkg::ST_MUL && ov_q) begin
      case (step_q)
        5'd0:    inter_q <= mul_p;
        5'd1:    a1_q    <= mul_p;
        default: a2_q    <= mul_p;
      endcase
    end
    if (state_q == bibm_pkg::ST_UNI) begin
      uni_q <= UW'(a1_q) + UW'(a2_q) - UW'(inter_q);
      rem_q <= RW'(inter_q);
      quo_q <= '0;
    end
    if (state_q == bibm_pkg::ST_DIV) begin
      quo_q <= {quo_q[QW-2:0], div_ge};
      rem_q <= {div_rem[RW-2:0], 1'b0};
    end
    if (state_q == bibm_pkg::ST_CMP && (!any_q || quo_q > best_q)) begin
      best_q     <= quo_q;
      best_idx_q <= idx_q;
    end
    if (state_q == bibm_pkg::ST_DONE && out_free) begin
      out_iou_q   <= best_q;
      out_idx_q   <= best_idx_ext[OW-1:0];
      out_match_q <= any_q;
    end
  end

  assign best_idx_ext  = {{OW{1'b0}}, best_idx_q};
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, out_idx_q, out_iou_q};
  assign m_axis_tuser  = out_match_q;

endmodule

`default_nettype wire
